### design/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
`timescale 1ns / 1ps
package ffa_pkg;
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [0:0] REG_HEADER_BYTES  = 1'b0;
  localparam logic [0:0] REG_SPLIT_MINIMUM = 1'b1;

  localparam logic [7:0]  HEADER_RESET = 8'd8;
  localparam logic [15:0] SPLIT_RESET  = 16'd24;
  localparam int          LEN_BITS     = 32;
  localparam int          ADDR_BITS    = 32;
endpackage

### design/ffa_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] block_address;
  logic [31:0] block_length;
  logic [31:0] request_size;
  modport source (output valid, opcode, block_address, block_length, request_size,
                  input ready);
  modport sink (input valid, opcode, block_address, block_length, request_size,
                output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] user_address;
  logic [31:0] usable_size;
  modport source (output valid, status, user_address, usable_size, input ready);
  modport sink (input valid, status, user_address, usable_size, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/first_fit_free_list_allocator_core.sv
// Top level: first-fit free segment allocator with coalescing.
//
// Channels: req (sink) takes allocate or free requests; rsp (source) returns
// one result per request; cfg (sink) writes header_bytes (index 0) and
// split_minimum (index 1), always ready.
// A request is taken only in IDLE. The segment table lives in a memory with
// one read port; a sequencer walks it one entry at a time (address, then
// registered data), first for the search and then, when a slot is inserted
// or dropped, to move the entries that follow it.
// The result sits in an output register; the next request is taken while it
// waits, and its own result waits until rsp is taken.
// Reset empties the table (count zero) and loads header 8 and split 24;
// no clearing pass is needed because only the first count entries are read.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_core #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp,
  ffa_cfg_if.sink   cfg
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = ffa_pkg::ADDR_BITS;
  localparam int LW = ffa_pkg::LEN_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_PREV  = 9'b000001000,
    S_PCHK  = 9'b000010000,
    S_SHR   = 9'b000100000,
    S_SHW   = 9'b001000000,
    S_SHL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [AW-1:0] mem_start [ENTRIES];
  logic [LW-1:0] mem_len [ENTRIES];
  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wr_addr;
  logic [AW-1:0] wr_start;
  logic [LW-1:0] wr_len;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          op;
  logic [AW-1:0] a;
  logic [LW-1:0] l;
  logic [LW-1:0] rq;
  logic [LW-1:0] lnew;
  logic          mnext;
  logic          shl;
  logic [7:0]    header_bytes;
  logic [15:0]   split_minimum;
  logic [1:0]    s_status;
  logic [31:0]   s_uaddr;
  logic [31:0]   s_usable;
  logic [1:0]    r_status;
  logic [31:0]   r_uaddr;
  logic [31:0]   r_usable;
  logic          out_valid;
  logic          pend;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr] <= wr_len;
    end
    rd_start <= mem_start[rd_addr];
    rd_len <= mem_len[rd_addr];
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= ffa_pkg::HEADER_RESET;
      split_minimum <= ffa_pkg::SPLIT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == ffa_pkg::REG_HEADER_BYTES) header_bytes <= cfg.data[7:0];
      else split_minimum <= cfg.data;
    end
  end

  assign req.ready = (state == S_IDLE) && !pend;
  assign rsp.valid = out_valid;
  assign rsp.status = r_status;
  assign rsp.user_address = r_uaddr;
  assign rsp.usable_size = r_usable;

  logic [LW:0]   hdr_ext;
  logic [LW:0]   ends_at;
  logic [LW:0]   sum_len;
  logic [LW:0]   fit_len;
  logic [LW-1:0] left;
  always_comb begin
    hdr_ext = {{(LW-7){1'b0}}, header_bytes};
    ends_at = {1'b0, a} + {1'b0, l};
    sum_len = {1'b0, rd_len} + {1'b0, (state == S_PCHK) ? lnew : l};
    fit_len = {1'b0, rq} + hdr_ext;
    left = rd_len - rq;
    rd_addr = (state == S_SHR) ? IW'(idx - 1'b1) : idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      if (pend && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        r_status <= s_status;
        r_uaddr <= s_uaddr;
        r_usable <= s_usable;
        pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          op <= req.opcode;
          a <= req.block_address[AW-1:0];
          l <= req.block_length;
          rq <= (req.request_size < {24'd0, header_bytes}) ?
                {24'd0, header_bytes} : req.request_size;
          idx <= '0;
          s_uaddr <= '0;
          s_usable <= '0;
          s_status <= ffa_pkg::ST_DONE;
          if (req.opcode == ffa_pkg::OP_FREE && req.block_length == '0) begin
            pend <= 1'b1;
          end else if (count == '0) begin
            idx <= '0;
            state <= S_CHK;
            pos <= '0;
          end else state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (op == ffa_pkg::OP_ALLOC) begin
            if (idx == count) begin
              s_status <= ffa_pkg::ST_NOFIT;
              pend <= 1'b1;
              state <= S_IDLE;
            end else if ({1'b0, rd_len} >= fit_len) begin
              s_uaddr <= 32'(rd_start + AW'(header_bytes));
              if (left > {16'd0, split_minimum}) begin
                s_usable <= rq - LW'(header_bytes);
                we <= 1'b1;
                wr_addr <= idx[IW-1:0];
                wr_start <= rd_start + AW'(rq);
                wr_len <= left;
                pend <= 1'b1;
                state <= S_IDLE;
              end else begin
                s_usable <= rd_len - LW'(header_bytes);
                pos <= idx;
                idx <= idx + 1'b1;
                shl <= 1'b1;
                state <= S_SHL;
              end
            end else begin
              idx <= idx + 1'b1;
              state <= (idx + 1'b1 == count) ? S_CHK : S_RD;
            end
          end else begin
            if (idx != count && rd_start <= a) begin
              idx <= idx + 1'b1;
              state <= (idx + 1'b1 == count) ? S_CHK : S_RD;
            end else begin
              pos <= idx;
              mnext <= (idx != count) && (ends_at == {1'b0, rd_start}) && !sum_len[LW];
              lnew <= ((idx != count) && (ends_at == {1'b0, rd_start}) && !sum_len[LW])
                      ? sum_len[LW-1:0] : l;
              if (idx != '0) begin
                idx <= idx - 1'b1;
                state <= S_PREV;
              end else state <= S_PCHK;
            end
          end
        end
        S_PREV: state <= S_PCHK;
        S_PCHK: begin
          if (pos != '0 && ({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, a} &&
              !sum_len[LW]) begin
            we <= 1'b1;
            wr_addr <= idx[IW-1:0];
            wr_start <= rd_start;
            wr_len <= sum_len[LW-1:0];
            if (mnext) begin
              idx <= pos + 1'b1;
              shl <= 1'b1;
              state <= S_SHL;
            end else begin
              pend <= 1'b1;
              state <= S_IDLE;
            end
          end else if (mnext) begin
            we <= 1'b1;
            wr_addr <= pos[IW-1:0];
            wr_start <= a;
            wr_len <= lnew;
            pend <= 1'b1;
            state <= S_IDLE;
          end else if (count == CW'(ENTRIES)) begin
            s_status <= ffa_pkg::ST_FULL;
            pend <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= count;
            state <= S_SHR;
          end
        end
        S_SHR: begin
          if (idx == pos) begin
            we <= 1'b1;
            wr_addr <= pos[IW-1:0];
            wr_start <= a;
            wr_len <= l;
            count <= count + 1'b1;
            pend <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
            state <= S_SHW;
          end
        end
        S_SHW: begin
          we <= 1'b1;
          wr_addr <= IW'(idx + 1'b1);
          wr_start <= rd_start;
          wr_len <= rd_len;
          state <= S_SHR;
        end
        S_SHL: begin
          if (idx >= count) begin
            count <= count - 1'b1;
            pend <= 1'b1;
            state <= S_IDLE;
          end else if (shl) begin
            shl <= 1'b0;
          end else begin
            we <= 1'b1;
            wr_addr <= IW'(idx - 1'b1);
            wr_start <= rd_start;
            wr_len <= rd_len;
            idx <= idx + 1'b1;
            shl <= 1'b1;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES)) else $error("segment count beyond table");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ffa_pkg::ST_DONE) |-> (rsp.user_address == '0))
    else $error("failed result carries an address");
`endif
endmodule
